### hw/rtl/ptx_pkg.sv
`default_nettype none

package ptx_pkg;

  // Fixed field widths
  localparam int DATA_W        = 32;
  localparam int ROW_W         = 2;
  localparam int N_ROWS        = 4;
  localparam int N_ENT         = N_ROWS * N_ROWS;
  localparam int ENT_W         = $clog2(N_ENT);
  localparam int FRAC_BITS_DEF = 16;

  // Full-precision product and sum of three products plus translation
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [DATA_W-1:0] word_t;

  // Item kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } kind_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Pipeline load strobes handed to the dot-product lanes
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/ptx_in_if.sv
`default_nettype none

interface ptx_in_if;
  logic                              valid;
  logic                              ready;
  ptx_pkg::kind_t                    kind;
  logic [ptx_pkg::ROW_W-1:0]         row_sel;
  logic signed [ptx_pkg::DATA_W-1:0] in_x;
  logic signed [ptx_pkg::DATA_W-1:0] in_y;
  logic signed [ptx_pkg::DATA_W-1:0] in_z;
  logic signed [ptx_pkg::DATA_W-1:0] in_w;

  modport source (output valid, kind, row_sel, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, kind, row_sel, in_x, in_y, in_z, in_w, output ready);
endinterface

`default_nettype wire

### hw/rtl/ptx_out_if.sv
`default_nettype none

interface ptx_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ptx_pkg::DATA_W-1:0] out_x;
  logic signed [ptx_pkg::DATA_W-1:0] out_y;
  logic signed [ptx_pkg::DATA_W-1:0] out_z;
  logic signed [ptx_pkg::DATA_W-1:0] out_w;
  logic                              saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

`default_nettype wire

### hw/rtl/ptx_matrix.sv
`default_nettype none

// Column-major 4x4 matrix; entry (row r, col c) sits at index r + 4*c.
module ptx_matrix #(
  parameter int FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      wr_en,
  input  wire logic [ptx_pkg::ROW_W-1:0]                 wr_row,
  input  wire logic [ptx_pkg::N_ROWS-1:0][ptx_pkg::DATA_W-1:0] wr_data,
  output logic      [ptx_pkg::N_ENT-1:0][ptx_pkg::DATA_W-1:0]  mat
);

  localparam int DW = ptx_pkg::DATA_W;
  localparam logic [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;

  for (genvar i = 0; i < ptx_pkg::N_ENT; i++) begin : g_ent
    localparam int ROW = i % ptx_pkg::N_ROWS;
    localparam int COL = i / ptx_pkg::N_ROWS;
    localparam logic [DW-1:0] RST_VAL = (ROW == COL) ? ONE : '0;

    logic [DW-1:0] ent_r;

    // Entry resets to identity, load writes its column slot of the row
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ent_r <= RST_VAL;
      end else if (wr_en && (wr_row == ptx_pkg::ROW_W'(ROW))) begin
        ent_r <= wr_data[COL];
      end
    end

    assign mat[i] = ent_r;
  end

endmodule

`default_nettype wire

### hw/rtl/ptx_dot.sv
`default_nettype none

// One matrix row: products registered, then sum with the scaled translation.
module ptx_dot #(
  parameter int FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire ptx_pkg::ctl_t                            ctl,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        x,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        y,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        z,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        m0,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        m1,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        m2,
  input  wire logic signed [ptx_pkg::DATA_W-1:0]        tr,
  output logic signed [ptx_pkg::SUM_W-1:0]              sum
);

  localparam int DW = ptx_pkg::DATA_W;
  localparam int PW = ptx_pkg::PROD_W;
  localparam int SW = ptx_pkg::SUM_W;

  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [DW-1:0] tr_r;
  logic signed [SW-1:0] tr_sh;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] sum_r;

  // 32x32 signed products, exact
  assign p0_nxt = $signed({{DW{x[DW-1]}}, x}) * $signed({{DW{m0[DW-1]}}, m0});
  assign p1_nxt = $signed({{DW{y[DW-1]}}, y}) * $signed({{DW{m1[DW-1]}}, m1});
  assign p2_nxt = $signed({{DW{z[DW-1]}}, z}) * $signed({{DW{m2[DW-1]}}, m2});

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      tr_r <= tr;
    end
  end

  // Translation carries w = 1, scaled to product precision
  assign tr_sh   = SW'(tr_r) <<< FRAC_BITS;
  assign sum_nxt = SW'(p0_r) + SW'(p1_r) + SW'(p2_r) + tr_sh;

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

### hw/rtl/ptx_out.sv
`default_nettype none

// Floor shift, clamp to 32 bits and hold the result item until taken.
module ptx_out #(
  parameter int FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              sum_vld,
  input  wire logic [ptx_pkg::N_ROWS-1:0][ptx_pkg::SUM_W-1:0]    sums,
  output logic                                                   out_free,
  ptx_out_if.source                                              out_ch
);

  localparam int DW = ptx_pkg::DATA_W;
  localparam int SW = ptx_pkg::SUM_W;
  localparam int NR = ptx_pkg::N_ROWS;

  logic [NR-1:0][DW-1:0] res_nxt;
  logic [NR-1:0][DW-1:0] res_r;
  logic [NR-1:0]         clip;
  logic                  sat_r;
  logic                  vld_r, vld_nxt;
  logic                  load;

  // Per lane: bits above the result word must all match the sign
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      clip[r] = !((&sums[r][SW-1:FRAC_BITS+DW-1]) || !(|sums[r][SW-1:FRAC_BITS+DW-1]));
      if (!clip[r]) begin
        res_nxt[r] = sums[r][FRAC_BITS+DW-1:FRAC_BITS];
      end else if (sums[r][SW-1]) begin
        res_nxt[r] = ptx_pkg::WORD_MIN;
      end else begin
        res_nxt[r] = ptx_pkg::WORD_MAX;
      end
    end
  end

  assign out_free = !vld_r || out_ch.ready;
  assign load     = sum_vld && out_free;
  assign vld_nxt  = out_free ? sum_vld : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
      sat_r <= |clip;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.out_x     = res_r[0];
  assign out_ch.out_y     = res_r[1];
  assign out_ch.out_z     = res_r[2];
  assign out_ch.out_w     = res_r[3];
  assign out_ch.saturated = sat_r;

endmodule

`default_nettype wire

### hw/rtl/point_transform_4x4.sv
`default_nettype none

// Homogeneous 4x4 vertex transform, signed fixed point with FRAC_BITS fraction
// bits. A load item (kind 0) writes one matrix row and gives no result; a
// transform item (kind 1) gives one result: the matrix times the point
// (x, y, z, 1), floor-shifted and clamped to 32 bits, with a flag if any lane
// clamped. One item is taken every clock until backpressure on the result
// channel has filled the three stages and stalls the input. The twelve
// 32x32 products of a transform item are registered at the edge that accepts
// it, then the four-term sums, then the clamped result in the output
// register. A row load is seen by the very next transform item.
module point_transform_4x4 #(
  parameter int FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptx_in_if.sink      in_ch,
  ptx_out_if.source   out_ch
);

  localparam int NR = ptx_pkg::N_ROWS;
  localparam int DW = ptx_pkg::DATA_W;
  localparam int SW = ptx_pkg::SUM_W;

  logic                          acc, ld_acc, xf_acc;
  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s2_vld_r, s2_vld_nxt;
  logic                          s1_free, s2_free, out_free;
  ptx_pkg::ctl_t                 ctl;
  logic [NR-1:0][DW-1:0]         row_data;
  logic [ptx_pkg::N_ENT-1:0][DW-1:0] mat;
  logic [NR-1:0][SW-1:0]         sums;

  // Handshake and stage advance
  assign s2_free     = !s2_vld_r || out_free;
  assign s1_free     = !s1_vld_r || s2_free;
  assign in_ch.ready = s1_free;

  assign acc    = in_ch.valid && in_ch.ready;
  assign xf_acc = acc && (in_ch.kind == ptx_pkg::KIND_XFORM);
  assign ld_acc = acc && (in_ch.kind == ptx_pkg::KIND_LOAD);

  assign ctl.s1_load = xf_acc;
  assign ctl.s2_load = s1_vld_r && s2_free;

  assign s1_vld_nxt = s1_free ? xf_acc : 1'b1;
  assign s2_vld_nxt = s2_free ? s1_vld_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Matrix storage
  assign row_data[0] = in_ch.in_x;
  assign row_data[1] = in_ch.in_y;
  assign row_data[2] = in_ch.in_z;
  assign row_data[3] = in_ch.in_w;

  ptx_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ld_acc),
    .wr_row  (in_ch.row_sel),
    .wr_data (row_data),
    .mat     (mat)
  );

  // One dot-product lane per output component
  for (genvar r = 0; r < NR; r++) begin : g_lane
    ptx_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk (clk),
      .ctl (ctl),
      .x   (in_ch.in_x),
      .y   (in_ch.in_y),
      .z   (in_ch.in_z),
      .m0  ($signed(mat[r])),
      .m1  ($signed(mat[r + NR])),
      .m2  ($signed(mat[r + 2*NR])),
      .tr  ($signed(mat[r + 3*NR])),
      .sum (sums[r])
    );
  end

  ptx_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum_vld  (s2_vld_r),
    .sums     (sums),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  // Checks
  a_s1_from_xform: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !$past(s1_vld_r)) |-> $past(xf_acc))
    else $error("stage 1 filled without a transform item");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready && s1_vld_r && s2_vld_r))
    else $error("input stalled while the pipeline has room");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.out_x == ptx_pkg::WORD_MAX || out_ch.out_x == ptx_pkg::WORD_MIN ||
       out_ch.out_y == ptx_pkg::WORD_MAX || out_ch.out_y == ptx_pkg::WORD_MIN ||
       out_ch.out_z == ptx_pkg::WORD_MAX || out_ch.out_z == ptx_pkg::WORD_MIN ||
       out_ch.out_w == ptx_pkg::WORD_MAX || out_ch.out_w == ptx_pkg::WORD_MIN))
    else $error("saturation flag set with no clamped component");

  a_row_load: assert property (@(posedge clk) disable iff (!rst_n)
    ld_acc |=> (mat[ptx_pkg::ENT_W'($past(in_ch.row_sel))] == $past(in_ch.in_x)))
    else $error("row load did not reach column 0 of the matrix");

endmodule

`default_nettype wire

### test/point_transform_4x4_test.sv
`timescale 1ns / 100ps

// One transformed vertex as it leaves the block
typedef struct {
  ptx_pkg::word_t x;
  ptx_pkg::word_t y;
  ptx_pkg::word_t z;
  ptx_pkg::word_t w;
  logic           saturated;
} vertex_t;

// Keeps its own copy of the matrix and the vertices still owed by the block
class vertex_predictor;
  localparam int FRAC = ptx_pkg::FRAC_BITS_DEF;

  ptx_pkg::word_t mat [ptx_pkg::N_ENT];
  vertex_t        expected_vertices [$];
  int             mismatches;

  function new();
    for (int i = 0; i < ptx_pkg::N_ENT; i++) mat[i] = '0;
    for (int i = 0; i < ptx_pkg::N_ROWS; i++) mat[i * 5] = 1 <<< FRAC;
    mismatches = 0;
  endfunction

  // Accepted input item: a row load updates the matrix, a point queues a vertex
  function void note_item(ptx_pkg::kind_t kind, logic [1:0] row,
                          ptx_pkg::word_t x, ptx_pkg::word_t y,
                          ptx_pkg::word_t z, ptx_pkg::word_t w);
    vertex_t             v;
    ptx_pkg::word_t      lane [4];
    logic signed [67:0]  acc;
    logic signed [67:0]  trans;
    logic signed [67:0]  lim_hi;
    logic signed [67:0]  lim_lo;
    if (kind == ptx_pkg::KIND_LOAD) begin
      mat[row]      = x;
      mat[row + 4]  = y;
      mat[row + 8]  = z;
      mat[row + 12] = w;
      return;
    end
    lim_hi = ptx_pkg::WORD_MAX;
    lim_lo = ptx_pkg::WORD_MIN;
    v.saturated = 1'b0;
    for (int r = 0; r < ptx_pkg::N_ROWS; r++) begin
      // exact sum, floor shift, then clamp to 32 bits
      trans = mat[r + 12];
      acc = x * mat[r] + y * mat[r + 4] + z * mat[r + 8] + (trans <<< FRAC);
      acc = acc >>> FRAC;
      if (acc > lim_hi) begin
        acc = lim_hi;
        v.saturated = 1'b1;
      end else if (acc < lim_lo) begin
        acc = lim_lo;
        v.saturated = 1'b1;
      end
      lane[r] = acc[31:0];
    end
    v.x = lane[0];
    v.y = lane[1];
    v.z = lane[2];
    v.w = lane[3];
    expected_vertices.push_back(v);
  endfunction

  function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Accepted result: compare with the oldest vertex owed
  function void check_result(vertex_t got);
    vertex_t e;
    if (expected_vertices.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h %h %h %h sat %b",
               $time, got.x, got.y, got.z, got.w, got.saturated);
      mismatches++;
      return;
    end
    e = expected_vertices.pop_front();
    compare_field("out_x", e.x, got.x);
    compare_field("out_y", e.y, got.y);
    compare_field("out_z", e.z, got.z);
    compare_field("out_w", e.w, got.w);
    compare_field("saturated", {31'b0, e.saturated}, {31'b0, got.saturated});
  endfunction
endclass

module point_transform_4x4_test;

  localparam int ONE        = 1 << ptx_pkg::FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  int   src_idle;
  int   sink_idle;
  int   idle_cycles = 0;

  ptx_in_if  in_ch ();
  ptx_out_if out_ch ();

  vertex_predictor preds = new();

  point_transform_4x4 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Monitor: check results first, then note inputs taken at the same edge
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.x = out_ch.out_x;
        got.y = out_ch.out_y;
        got.z = out_ch.out_z;
        got.w = out_ch.out_w;
        got.saturated = out_ch.saturated;
        preds.check_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        preds.note_item(in_ch.kind, in_ch.row_sel, in_ch.in_x, in_ch.in_y,
                        in_ch.in_z, in_ch.in_w);
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Idle cycle by cycle at the sender's rate, then hold the item until taken
  task automatic send_item(ptx_pkg::kind_t kind, logic [1:0] row,
                           ptx_pkg::word_t x, ptx_pkg::word_t y,
                           ptx_pkg::word_t z, ptx_pkg::word_t w);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.row_sel <= row;
    in_ch.in_x    <= x;
    in_ch.in_y    <= y;
    in_ch.in_z    <= z;
    in_ch.in_w    <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic ptx_pkg::word_t rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic ptx_pkg::word_t rand_special();
    case ($urandom_range(6))
      0: return ptx_pkg::WORD_MAX;
      1: return ptx_pkg::WORD_MIN;
      2: return '0;
      3: return 1;
      4: return -1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  // Matrix entries: mostly modest gains, some full range and edge values
  function automatic ptx_pkg::word_t rand_entry();
    int pick;
    pick = $urandom_range(19);
    if (pick < 3) return rand_special();
    if (pick < 7) return $urandom;
    return rand_span(4 * ONE);
  endfunction

  function automatic ptx_pkg::word_t rand_coord();
    int pick;
    pick = $urandom_range(19);
    if (pick < 2) return rand_special();
    if (pick < 5) return $urandom;
    return rand_span(1024 * ONE);
  endfunction

  task automatic send_load(logic [1:0] row);
    send_item(ptx_pkg::KIND_LOAD, row, rand_entry(), rand_entry(), rand_entry(),
              rand_entry());
  endtask

  task automatic send_point();
    send_item(ptx_pkg::KIND_XFORM, 2'($urandom), rand_coord(), rand_coord(),
              rand_coord(), $urandom);
  endtask

  // Mostly full matrix loads followed by point bursts; some lone items as noise
  task automatic run_random(int count);
    int sent;
    int first;
    int burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_load(2'($urandom));
        else send_point();
        sent++;
      end else begin
        first = $urandom_range(3);
        for (int i = 0; i < ptx_pkg::N_ROWS; i++) send_load(2'(first + i));
        burst = $urandom_range(4, 16);
        repeat (burst) send_point();
        sent += ptx_pkg::N_ROWS + burst;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= ptx_pkg::KIND_LOAD;
    in_ch.row_sel <= '0;
    in_ch.in_x    <= '0;
    in_ch.in_y    <= '0;
    in_ch.in_z    <= '0;
    in_ch.in_w    <= '0;
    src_idle  = 13;
    sink_idle = 82;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix after reset; row select and w are ignored on a point
    send_item(ptx_pkg::KIND_XFORM, 2'd3, ONE, 2 * ONE, 3 * ONE, ptx_pkg::WORD_MAX);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, ptx_pkg::WORD_MAX, ptx_pkg::WORD_MIN, '0,
              ptx_pkg::WORD_MIN);
    send_item(ptx_pkg::KIND_XFORM, 2'd1, -1, -1, -1, '0);

    // Extreme rows: positive and negative clamping, floor on tiny negatives
    send_item(ptx_pkg::KIND_LOAD, 2'd0, ptx_pkg::WORD_MAX, ptx_pkg::WORD_MAX,
              ptx_pkg::WORD_MAX, ptx_pkg::WORD_MAX);
    send_item(ptx_pkg::KIND_LOAD, 2'd1, ptx_pkg::WORD_MIN, ptx_pkg::WORD_MIN,
              ptx_pkg::WORD_MIN, ptx_pkg::WORD_MIN);
    send_item(ptx_pkg::KIND_LOAD, 2'd2, 1, 1, 1, '0);
    send_item(ptx_pkg::KIND_LOAD, 2'd3, ptx_pkg::WORD_MIN, ptx_pkg::WORD_MAX, '0,
              ptx_pkg::WORD_MIN);
    send_item(ptx_pkg::KIND_XFORM, 2'd2, ptx_pkg::WORD_MAX, ptx_pkg::WORD_MAX,
              ptx_pkg::WORD_MAX, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd2, ptx_pkg::WORD_MIN, ptx_pkg::WORD_MIN,
              ptx_pkg::WORD_MIN, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, -1, -1, -1, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, -1, '0, '0, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, '0, '0, '0, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, ptx_pkg::WORD_MIN, ptx_pkg::WORD_MAX,
              ptx_pkg::WORD_MIN, '0);

    // Back to identity, row by row
    send_item(ptx_pkg::KIND_LOAD, 2'd3, '0, '0, '0, ONE);
    send_item(ptx_pkg::KIND_LOAD, 2'd2, '0, '0, ONE, '0);
    send_item(ptx_pkg::KIND_LOAD, 2'd1, '0, ONE, '0, '0);
    send_item(ptx_pkg::KIND_LOAD, 2'd0, ONE, '0, '0, '0);
    send_item(ptx_pkg::KIND_XFORM, 2'd0, ptx_pkg::WORD_MIN, ptx_pkg::WORD_MAX, -ONE, '0);

    run_random(500);
    src_idle  = 82;
    sink_idle = 13;
    run_random(500);
    src_idle  = 0;
    sink_idle = 0;
    run_random(500);
    in_ch.valid <= 1'b0;

    // Drain, then allow a few pipeline depths for stray results
    while (preds.expected_vertices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (preds.mismatches == 0 && preds.expected_vertices.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/ptx_pkg.sv
hw/rtl/ptx_in_if.sv
hw/rtl/ptx_out_if.sv
hw/rtl/ptx_matrix.sv
hw/rtl/ptx_dot.sv
hw/rtl/ptx_out.sv
hw/rtl/point_transform_4x4.sv
test/point_transform_4x4_test.sv
